// ===== rtl/u8u16_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

	localparam int unsigned MAX_RES = 3;

	localparam logic [15:0] REPL_CHAR = 16'hFFFD;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [25:0] SUPP_BASE = 26'h0010000;
	localparam logic [15:0] CAP_RESET = 16'hFFFF;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;

	// Sequence length codes
	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_1   = 3'd1;
	localparam logic [2:0] LEN_2   = 3'd2;
	localparam logic [2:0] LEN_3   = 3'd3;
	localparam logic [2:0] LEN_4   = 3'd4;

	// Per-string decoder state
	typedef struct packed {
		logic [1:0]  pcnt;
		logic [15:0] ucnt;
		logic        ovf;
	} dec_state_t;

	// Result set of one input byte
	typedef struct packed {
		logic [1:0]  n_units;
		logic [15:0] base;
		logic        ovf;
	} res_info_t;

	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] n;
		if (!b[7])
			n = LEN_1;
		else if ((b & LEAD2_MASK) == LEAD2_PAT)
			n = LEN_2;
		else if ((b & LEAD3_MASK) == LEAD3_PAT)
			n = LEN_3;
		else if ((b & LEAD4_MASK) == LEAD4_PAT)
			n = LEN_4;
		else
			n = LEN_BAD;
		return n;
	endfunction

endpackage

// ===== rtl/u8u16_decode.sv =====
// Combinational decode of pending bytes plus one new byte into up to three code units.
module u8u16_decode import u8u16_pkg::*; (
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	input  logic [7:0]  pend [3],
	input  dec_state_t  cur,
	input  logic [15:0] capacity,
	output logic [7:0]  pend_nx [3],
	output dec_state_t  nxt,
	output res_info_t   info,
	output logic [15:0] unit [MAX_RES]
);

	logic [7:0]  bytes [4];
	logic [2:0]  len;
	logic [16:0] diff;
	logic [2:0]  room;
	logic [2:0]  pos;
	logic [2:0]  need;
	logic [2:0]  sum;
	logic [1:0]  e;
	logic [1:0]  keep;
	logic        done;
	logic        ovf;
	logic [7:0]  b0, b1, b2, b3;
	logic [25:0] cp;
	logic [15:0] v0, v1;
	logic        em0, em1;

	always_comb begin
		len = {1'b0, cur.pcnt} + 3'd1;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < {1'b0, cur.pcnt})
				bytes[k] = (k < 3) ? pend[k[1:0] == 2'd3 ? 2'd0 : k[1:0]] : 8'h00;
			else if (3'(k) == {1'b0, cur.pcnt})
				bytes[k] = in_byte;
			else
				bytes[k] = 8'h00;
		end

		// room left, saturated at 7 (enough for three units per byte)
		diff = {1'b0, capacity} - {1'b0, cur.ucnt};
		if (diff[16])
			room = 3'd0;
		else if (diff[15:0] > 16'd7)
			room = 3'd7;
		else
			room = diff[2:0];

		pos  = 3'd0;
		e    = 2'd0;
		keep = 2'd0;
		done = 1'b0;
		ovf  = cur.ovf;
		for (int i = 0; i < MAX_RES; i++)
			unit[i] = 16'h0000;

		// at most four sequences fit in four bytes
		for (int s = 0; s < 4; s++) begin
			b0   = bytes[pos[1:0]];
			b1   = bytes[2'(pos + 3'd1)];
			b2   = bytes[2'(pos + 3'd2)];
			b3   = bytes[2'(pos + 3'd3)];
			need = seq_len(b0);
			sum  = pos + need;
			cp   = 26'(({b0[2:0], b1[5:0], b2[5:0], b3[5:0]}) - SUPP_BASE);
			em0  = 1'b0;
			em1  = 1'b0;
			v0   = REPL_CHAR;
			v1   = 16'h0000;
			if (!done && pos < len) begin
				if (room <= {1'b0, e}) begin
					ovf  = 1'b1;
					done = 1'b1;
				end else if (need == LEN_BAD) begin
					em0 = 1'b1;
					pos = pos + 3'd1;
				end else if (sum > len) begin
					if (!last_byte) begin
						keep = 2'(len - pos);
						done = 1'b1;
					end else begin
						em0 = 1'b1;
						pos = pos + 3'd1;
					end
				end else begin
					case (need)
						LEN_1: begin
							em0 = 1'b1;
							v0  = {8'h00, b0};
						end
						LEN_2: begin
							em0 = 1'b1;
							v0  = {5'b0, b0[4:0], b1[5:0]};
						end
						LEN_3: begin
							em0 = 1'b1;
							v0  = {b0[3:0], b1[5:0], b2[5:0]};
						end
						default: begin
							// surrogate pair, dropped whole when only one slot is left
							if (room > {1'b0, e} + 3'd1) begin
								em0 = 1'b1;
								em1 = 1'b1;
								v0  = HI_SURR + cp[25:10];
								v1  = LO_SURR + {6'b0, cp[9:0]};
							end
						end
					endcase
					pos = sum;
				end
			end
			if (em0 && e < 2'(MAX_RES)) begin
				unit[e] = v0;
				e = e + 2'd1;
			end
			if (em1 && e < 2'(MAX_RES)) begin
				unit[e] = v1;
				e = e + 2'd1;
			end
		end

		for (int k = 0; k < 3; k++)
			pend_nx[k] = bytes[2'(pos + 3'(k))];

		info.n_units = e;
		info.base    = cur.ucnt;
		info.ovf     = ovf;

		nxt.pcnt = last_byte ? 2'd0 : keep;
		nxt.ucnt = last_byte ? 16'd0 : cur.ucnt + {14'b0, e};
		nxt.ovf  = last_byte ? 1'b0 : ovf;
	end

endmodule

// ===== rtl/u8u16_out.sv =====
// Result register: holds one byte's result set and hands it out one word per cycle while m_axis_tready is high.
module u8u16_out import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_info_t   info,
	input  logic [15:0] unit [MAX_RES],
	output logic        can_load,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // code_unit[15:0], units_written[31:16], overflow[32]
	output logic        m_axis_tuser,  // unit_valid
	output logic        m_axis_tlast   // run_end
);

	logic        valid_q;
	logic [1:0]  ptr_q;
	res_info_t   info_q;
	logic [15:0] unit_q [MAX_RES];
	logic        take;
	logic        at_end;
	logic        has_units;
	logic [15:0] code;
	logic [15:0] wr_cnt;

	assign has_units = (info_q.n_units != 2'd0);
	assign at_end    = !has_units || (ptr_q == info_q.n_units - 2'd1);
	assign take      = valid_q && m_axis_tready;
	assign can_load  = !valid_q || (take && at_end);

	assign code   = has_units ? unit_q[ptr_q] : 16'h0000;
	assign wr_cnt = info_q.base + (has_units ? {14'b0, ptr_q} + 16'd1 : 16'd0);

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {7'b0, info_q.ovf, wr_cnt, code};
	assign m_axis_tuser  = has_units;
	assign m_axis_tlast  = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			ptr_q   <= 2'd0;
		end else if (take && at_end) begin
			valid_q <= 1'b0;
		end else if (take) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			info_q <= info;
			unit_q <= unit;
		end
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && has_units |-> ptr_q < info_q.n_units)
		else $error("result pointer past unit count");

	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !at_end && !load |=> ptr_q == $past(ptr_q) + 2'd1)
		else $error("result pointer did not advance");

	a_load_ok: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result register overwritten while busy");

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: input register, string state, result stage.
//
// Streams one UTF-8 string in as bytes (s_axis_tlast marks its final byte) and returns
// UTF-16 code units. Every accepted byte yields a result set of one to three words:
// a status-only word (tuser low) when the byte completes nothing, otherwise one word per
// emitted unit; tlast marks the final word of each byte's set. Words carry the running
// unit count of the string and the overflow flag. Throughput is one byte per cycle while
// each byte yields a single word and the receiver is ready; a byte yielding more than one
// word holds the result register, which hands out one word per cycle, until all are taken.
// Each byte goes through the input register, then the result register. Lead
// bytes pick the sequence length, continuation bytes are not checked, truncated
// sequences at end of string and stray bytes give U+FFFD, four-byte values become a
// surrogate pair (dropped whole if only one slot remains). Output stops at the capacity
// register (reset 65535); overflow is set if bytes remain once it is reached. Write
// capacity only while the block is idle. String state clears after the last byte.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
	input  logic        s_axis_tlast,   // last_byte
	// code unit stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // code_unit[15:0], units_written[31:16], overflow[32]
	output logic        m_axis_tuser,   // unit_valid
	output logic        m_axis_tlast    // run_end
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [15:0] cap_q;
	logic [7:0]  pend_q [3];
	dec_state_t  st_q;

	logic [7:0]  pend_nx [3];
	dec_state_t  st_nx;
	res_info_t   info;
	logic [15:0] unit [MAX_RES];
	logic        can_load;
	logic        adv;

	// the byte in the input register moves into the result register
	assign adv           = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cap_q    <= CAP_RESET;
			st_q     <= '0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
			if (adv)
				st_q <= st_nx;
		end
	end

	// payload, no reset; pending bytes are only read below the pending count
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv)
			pend_q <= pend_nx;
	end

	u8u16_decode u_decode (
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.pend      (pend_q),
		.cur       (st_q),
		.capacity  (cap_q),
		.pend_nx   (pend_nx),
		.nxt       (st_nx),
		.info      (info),
		.unit      (unit)
	);

	u8u16_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv),
		.info          (info),
		.unit          (unit),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q.pcnt == 2'd0 && st_q.ucnt == 16'd0 && !st_q.ovf)
		else $error("string state not cleared after last byte");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("status-only word not marked as end of set");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> st_q == $past(st_q))
		else $error("string state changed without a byte");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
module tb_top;
	import u8u16_pkg::*;

	localparam int SETTLE_CYCLES = 4;     // result path is two registers deep
	localparam int QUIET_LIMIT   = 1000;  // cycles without any handshake before giving up
	localparam int RANDOM_BYTES  = 175;
	localparam int REPORT_LIMIT  = 40;

	// One output word as the checker sees it
	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        run_end;
		logic [15:0] units_written;
		logic        overflow;
	} unit_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // in_byte[7:0]
	logic        s_axis_tlast = 1'b0; // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // code_unit[15:0], units_written[31:16], overflow[32]
	logic        m_axis_tuser;        // unit_valid
	logic        m_axis_tlast;        // run_end

	// Decoder state mirrored by the testbench
	logic [15:0] cap_reg = CAP_RESET;
	logic [7:0]  held_bytes [3];
	int          held_count = 0;
	logic [15:0] unit_total = '0;
	logic        ovf_flag = 1'b0;

	unit_word_t  expected_units [$];

	// Idle controls and bookkeeping
	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int words_checked = 0;
	int cap_writes = 0;
	int ovf_words = 0;

	utf8_to_utf16_transcoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		if (b[7] == 1'b0)
			return LEN_1;
		if (b[7:5] == 3'b110)
			return LEN_2;
		if (b[7:4] == 4'b1110)
			return LEN_3;
		if (b[7:3] == 5'b11110)
			return LEN_4;
		return LEN_BAD;
	endfunction

	// Decode one byte against the mirrored state and queue the words it yields
	task automatic transcode_byte(input logic [7:0] in_b, input logic last);
		logic [7:0]  seq [4];
		logic [15:0] vals [3];
		logic [15:0] cnts [3];
		logic [15:0] nv [2];
		logic [7:0]  b;
		logic [2:0]  need;
		logic [20:0] code_pt;
		logic [31:0] offs;
		unit_word_t  w;
		int n_bytes, pos, adv, keep, n_out, n_new, k, e;
		n_bytes = 0;
		pos = 0;
		keep = 0;
		n_out = 0;
		for (k = 0; k < held_count; k++) begin
			seq[n_bytes] = held_bytes[k];
			n_bytes++;
		end
		seq[n_bytes] = in_b;
		n_bytes++;

		while (pos < n_bytes) begin
			b = seq[pos];
			need = lead_length(b);
			n_new = 0;
			adv = 1;
			// full destination: the rest of the string is dropped, pending bytes too
			if (unit_total >= cap_reg) begin
				ovf_flag = 1'b1;
				break;
			end
			if (need == LEN_BAD) begin
				n_new = 1;
				nv[0] = REPL_CHAR;
			end else if (pos + int'(need) > n_bytes) begin
				if (!last) begin
					keep = n_bytes - pos;
					for (k = 0; k < keep; k++)
						held_bytes[k] = seq[pos + k];
					break;
				end
				// truncated at end of string: lead becomes U+FFFD, the rest is rescanned
				n_new = 1;
				nv[0] = REPL_CHAR;
			end else begin
				adv = int'(need);
				case (need)
					LEN_1: begin
						n_new = 1;
						nv[0] = {8'h00, b};
					end
					LEN_2: begin
						n_new = 1;
						nv[0] = 16'({b[4:0], seq[pos + 1][5:0]});
					end
					LEN_3: begin
						n_new = 1;
						nv[0] = {b[3:0], seq[pos + 1][5:0], seq[pos + 2][5:0]};
					end
					default: begin
						code_pt = {b[2:0], seq[pos + 1][5:0], seq[pos + 2][5:0],
							seq[pos + 3][5:0]};
						offs = {11'd0, code_pt} - 32'h0001_0000;
						nv[0] = HI_SURR + offs[25:10];
						nv[1] = LO_SURR + {6'd0, offs[9:0]};
						// a pair with one slot left is dropped whole
						if ({1'b0, unit_total} + 17'd1 < {1'b0, cap_reg})
							n_new = 2;
					end
				endcase
			end
			for (e = 0; e < n_new; e++) begin
				if (n_out < MAX_RES) begin
					unit_total = unit_total + 16'd1;
					vals[n_out] = nv[e];
					cnts[n_out] = unit_total;
					n_out++;
				end
			end
			pos += adv;
		end
		held_count = keep;

		if (n_out == 0) begin
			w = '{code_unit: 16'h0000, unit_valid: 1'b0, run_end: 1'b1,
				units_written: unit_total, overflow: ovf_flag};
			expected_units.push_back(w);
		end else begin
			for (e = 0; e < n_out; e++) begin
				w = '{code_unit: vals[e], unit_valid: 1'b1, run_end: (e == n_out - 1),
					units_written: cnts[e], overflow: ovf_flag};
				expected_units.push_back(w);
			end
		end

		if (last) begin
			held_count = 0;
			unit_total = '0;
			ovf_flag = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (error_count < REPORT_LIMIT)
			$display("[%0t] %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Send one byte; tvalid stays up when the next byte follows without a gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = src_idle_en ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		transcode_byte(b, last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
		if (last)
			strings_sent++;
	endtask

	// Stop sending and let every queued word come out
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (expected_units.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap_reg = value;
		cap_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ASCII extremes, every lead length, overlong and out-of-range forms, stray bytes;
	// both sides run without gaps here
	task automatic test_basic_forms();
		logic [7:0] str [$];
		int k;
		str = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hC0, 8'h80, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'h80, 8'hFF, 8'hF8};
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		for (k = 0; k < str.size(); k++)
			send_byte(str[k], k == str.size() - 1);
		wait_for_results();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
	endtask

	// Sequences cut off by the end of the string
	task automatic test_truncation();
		// four-byte lead, then a three-byte lead, then ASCII: three words from one byte
		send_byte(8'hF0, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h41, 1'b1);
		// lone two-byte lead as the whole string
		send_byte(8'hC3, 1'b1);
	endtask

	// Zero capacity, dropped pair, exact fill, overflow, change in the middle of a string
	task automatic test_capacity();
		write_capacity(16'd0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);

		write_capacity(16'd2);
		send_byte(8'h41, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h43, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h43, 1'b1);

		write_capacity(16'hFFFF);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		write_capacity(16'd1);
		send_byte(8'hAC, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	// Mostly well-formed strings with random content, some noise and cut sequences
	task automatic send_random_string();
		logic [7:0] str_bytes [$];
		logic [31:0] rnd;
		logic [7:0] lead;
		int n_chars, kind, len, n_cont, k, c;
		n_chars = $urandom_range(1, 10);
		for (k = 0; k < n_chars; k++) begin
			kind = $urandom_range(0, 19);
			len = $urandom_range(1, 4);
			if (kind >= 17) begin
				str_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				rnd = $urandom;
				case (len)
					1: lead = {1'b0, rnd[6:0]};
					2: lead = {3'b110, rnd[4:0]};
					3: lead = {4'b1110, rnd[3:0]};
					default: lead = {5'b11110, rnd[2:0]};
				endcase
				str_bytes.push_back(lead);
				n_cont = len - 1;
				if (kind == 16 && n_cont > 0)
					n_cont = $urandom_range(0, n_cont - 1);
				for (c = 0; c < n_cont; c++)
					str_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
			end
		end
		for (k = 0; k < str_bytes.size(); k++)
			send_byte(str_bytes[k], k == str_bytes.size() - 1);
	endtask

	task automatic test_random();
		int start_bytes;
		bit paused;
		start_bytes = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: write_capacity(16'd0);
					1: write_capacity(16'hFFFF);
					2: write_capacity(16'($urandom_range(0, 65535)));
					default: write_capacity(16'($urandom_range(1, 12)));
				endcase
			end
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en = ($urandom_range(0, 3) != 0);
			send_random_string();
			// hold the sender once until the output side has fully caught up
			if (!paused && bytes_sent - start_bytes > RANDOM_BYTES / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
	endtask

	// Receiver: random stall before each word, ready held until the word is taken
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		unit_word_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			words_checked++;
			if (expected_units.size() == 0) begin
				report_mismatch("word with nothing expected", m_axis_tdata[31:0], '0);
			end else begin
				want = expected_units.pop_front();
				if (m_axis_tdata[15:0] !== want.code_unit)
					report_mismatch("code_unit", m_axis_tdata[15:0], want.code_unit);
				if (m_axis_tuser !== want.unit_valid)
					report_mismatch("unit_valid", m_axis_tuser, want.unit_valid);
				if (m_axis_tlast !== want.run_end)
					report_mismatch("run_end", m_axis_tlast, want.run_end);
				if (m_axis_tdata[31:16] !== want.units_written)
					report_mismatch("units_written", m_axis_tdata[31:16],
						want.units_written);
				if (m_axis_tdata[32] !== want.overflow)
					report_mismatch("overflow", m_axis_tdata[32], want.overflow);
				if (m_axis_tdata[39:33] !== '0)
					report_mismatch("tdata padding", m_axis_tdata[39:33], '0);
				if (want.overflow)
					ovf_words++;
			end
			stall_left = snk_idle_en ? $urandom_range(0, 3) : 0;
		end
	end

	// Watchdog: too long without any handshake means the block is stuck
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("utf8_to_utf16_transcoder: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_forms();
		test_truncation();
		test_capacity();
		test_random();

		wait_for_results();
		repeat (8) @(negedge clk);
		while (expected_units.size() > 0) begin
			report_mismatch("word never arrived", '0, expected_units[0].code_unit);
			void'(expected_units.pop_front());
		end

		$display("Run covered %0d bytes in %0d strings, %0d words checked, %0d with overflow.",
			bytes_sent, strings_sent, words_checked, ovf_words);
		$display("Capacity was rewritten %0d times, from zero up to full range; %0d mismatches.",
			cap_writes, error_count);
		if (error_count == 0)
			$display("utf8_to_utf16_transcoder: match");
		else
			$display("utf8_to_utf16_transcoder: mismatch");
		$finish;
	end

endmodule
